@@ rtl/voxel_occupancy_vote_filter_assert.svh @@
// ----------------------------------------------------------------------------
// voxel_occupancy_vote_filter_assert.svh
// Assertion macros shared by the filter RTL. They expect clk and rst_n
// in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef VOXEL_OCCUPANCY_VOTE_FILTER_ASSERT_SVH
`define VOXEL_OCCUPANCY_VOTE_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VOVF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VOVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vovf_pkg.sv @@
// ----------------------------------------------------------------------------
// vovf_pkg
// Types, constants and helpers for the voxel occupancy vote filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vovf_pkg;

    // field widths
    localparam int COUNT_W  = 24;
    localparam int THR_W    = 17;
    localparam int OCC_W    = 9;
    localparam int TALLY_W  = 5;
    localparam int PROD_W   = COUNT_W + THR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // occupancy codes, Q1.8
    localparam logic [OCC_W-1:0] OCC_FREE    = 9'd0;
    localparam logic [OCC_W-1:0] OCC_UNKNOWN = 9'd128;
    localparam logic [OCC_W-1:0] OCC_FILLED  = 9'd256;

    // 1.0 in Q1.16
    localparam logic [THR_W-1:0] Q16_ONE = 17'd65536;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0]   RST_FREE_RATIO_THRESHOLD = 17'd32768;
    localparam logic [COUNT_W-1:0] RST_MIN_FILLED_POINTS    = 24'd1;
    localparam logic [TALLY_W-1:0] RST_MIN_FREE_CAMERAS     = 5'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREE_RATIO_THRESHOLD = 2'd0,
        REG_MIN_FILLED_POINTS    = 2'd1,
        REG_MIN_FREE_CAMERAS     = 2'd2
    } cfg_reg_t;

    // products ready for the vote compare
    typedef struct packed {
        logic [PROD_W-1:0]  free_prod;   // free * (1.0 - thr)
        logic [PROD_W-1:0]  fill_prod;   // thr * filled
        logic               free_nz;
        logic               fill_nz;
        logic               thr_over;    // threshold above 1.0
        logic [OCC_W-1:0]   prior;
        logic               last;
    } vote_stage_t;

    // one result item
    typedef struct packed {
        logic [OCC_W-1:0]   new_occupancy;
        logic [TALLY_W-1:0] free_votes;
        logic [TALLY_W-1:0] filled_votes;
    } result_t;

    // saturating tally increment
    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
        return (t == TALLY_MAX) ? TALLY_MAX : t + 5'd1;
    endfunction

endpackage

@@ rtl/vovf_if.sv @@
// ----------------------------------------------------------------------------
// vovf_if
// Valid/ready channels for camera count items and filter results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vovf_item_if;
    logic                          valid;
    logic                          ready;
    logic [vovf_pkg::COUNT_W-1:0]  free_rays;
    logic [vovf_pkg::COUNT_W-1:0]  filled_points;
    logic [vovf_pkg::OCC_W-1:0]    prior_occupancy;
    logic                          last_camera;

    modport source (output valid, free_rays, filled_points, prior_occupancy,
                    last_camera, input ready);
    modport sink   (input valid, free_rays, filled_points, prior_occupancy,
                    last_camera, output ready);
endinterface

interface vovf_result_if;
    logic                          valid;
    logic                          ready;
    logic [vovf_pkg::OCC_W-1:0]    new_occupancy;
    logic [vovf_pkg::TALLY_W-1:0]  free_votes;
    logic [vovf_pkg::TALLY_W-1:0]  filled_votes;

    modport source (output valid, new_occupancy, free_votes, filled_votes,
                    input ready);
    modport sink   (input valid, new_occupancy, free_votes, filled_votes,
                    output ready);
endinterface

@@ rtl/vovf_tally.sv @@
// ----------------------------------------------------------------------------
// vovf_tally
// Vote compare, saturating vote tallies and the occupancy decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_occupancy_vote_filter_assert.svh"

module vovf_tally (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vovf_pkg::TALLY_W-1:0]  min_free_cameras,
    input  vovf_pkg::vote_stage_t         stage,
    input  logic                          advance,
    output vovf_pkg::result_t             res
);

    logic [vovf_pkg::TALLY_W-1:0] free_tally_reg;
    logic [vovf_pkg::TALLY_W-1:0] free_tally_next;
    logic [vovf_pkg::TALLY_W-1:0] filled_tally_reg;
    logic [vovf_pkg::TALLY_W-1:0] filled_tally_next;
    logic                         ratio_free;
    logic                         free_vote;
    logic                         filled_vote;
    logic [vovf_pkg::TALLY_W-1:0] free_upd;
    logic [vovf_pkg::TALLY_W-1:0] filled_upd;

    // free fraction >= thr  <=>  free*(1-thr) >= thr*filled, for thr <= 1.0
    assign ratio_free = !stage.thr_over && (stage.free_prod >= stage.fill_prod);

    // at most one vote per camera
    always_comb
    begin
        if (stage.free_nz && stage.fill_nz)
        begin
            free_vote   = ratio_free;
            filled_vote = !ratio_free;
        end
        else
        begin
            free_vote   = stage.free_nz;
            filled_vote = stage.fill_nz;
        end
    end

    assign free_upd   = free_vote   ? vovf_pkg::sat_inc(free_tally_reg)   : free_tally_reg;
    assign filled_upd = filled_vote ? vovf_pkg::sat_inc(filled_tally_reg) : filled_tally_reg;

    // result for the item in this stage, counting its own vote
    always_comb
    begin
        res.free_votes   = free_upd;
        res.filled_votes = filled_upd;
        if (stage.prior > vovf_pkg::OCC_UNKNOWN)
            res.new_occupancy = stage.prior;
        else if (filled_upd != '0)
            res.new_occupancy = vovf_pkg::OCC_FILLED;
        else if (free_upd >= min_free_cameras)
            res.new_occupancy = vovf_pkg::OCC_FREE;
        else
            res.new_occupancy = vovf_pkg::OCC_UNKNOWN;
    end

    // tallies clear after the last camera of a voxel
    always_comb
    begin
        free_tally_next   = free_tally_reg;
        filled_tally_next = filled_tally_reg;
        if (advance)
        begin
            free_tally_next   = stage.last ? '0 : free_upd;
            filled_tally_next = stage.last ? '0 : filled_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_tally_reg   <= '0;
            filled_tally_reg <= '0;
        end
        else
        begin
            free_tally_reg   <= free_tally_next;
            filled_tally_reg <= filled_tally_next;
        end
    end

    `VOVF_ASSERT_NEXT(a_tally_clear, advance && stage.last, (free_tally_reg == '0) && (filled_tally_reg == '0), "tallies not cleared after last camera")
    `VOVF_ASSERT_NEXT(a_free_sat, advance && !stage.last && (free_tally_reg == vovf_pkg::TALLY_MAX), free_tally_reg == vovf_pkg::TALLY_MAX, "free tally wrapped")
    `VOVF_ASSERT_NEXT(a_filled_sat, advance && !stage.last && (filled_tally_reg == vovf_pkg::TALLY_MAX), filled_tally_reg == vovf_pkg::TALLY_MAX, "filled tally wrapped")

endmodule

@@ rtl/voxel_occupancy_vote_filter.sv @@
// ----------------------------------------------------------------------------
// voxel_occupancy_vote_filter
// Per-camera outlier gating, ratio products and vote tallying for one voxel.
// ----------------------------------------------------------------------------
// A last-camera result passes the input, product and result registers.
// Throughput: one item per cycle while the output is not stalled; set by the
// three-register pipeline (input, product, result) with a skid-free stall chain.
// Results waiting at the output do not stop intake until the pipe is full.
// Reset: async, active low; clears pipeline valids and tallies, config regs
// load their default values.
`timescale 1ns / 1ps

`include "voxel_occupancy_vote_filter_assert.svh"

module voxel_occupancy_vote_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vovf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vovf_pkg::CFG_DATA_W-1:0]   cfg_data,
    vovf_item_if.sink                         item,
    vovf_result_if.source                     result
);

    // configuration registers
    logic [vovf_pkg::THR_W-1:0]   thr_reg;
    logic [vovf_pkg::COUNT_W-1:0] min_filled_reg;
    logic [vovf_pkg::TALLY_W-1:0] min_free_reg;

    // stage 1: gated counts
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [vovf_pkg::COUNT_W-1:0] s1_free_reg;
    logic [vovf_pkg::COUNT_W-1:0] s1_fill_reg;
    logic [vovf_pkg::OCC_W-1:0]   s1_prior_reg;
    logic                         s1_last_reg;

    // stage 2: products
    logic                         s2_valid_reg;
    logic                         s2_valid_next;
    vovf_pkg::vote_stage_t        s2_reg;
    vovf_pkg::vote_stage_t        s2_next;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    vovf_pkg::result_t            out_reg;
    vovf_pkg::result_t            tally_res;

    logic                         accept;
    logic                         load2;
    logic                         adv3;
    logic                         thr_over;
    logic [vovf_pkg::THR_W-1:0]   thr_comp;

    // stall chain
    assign adv3   = s2_valid_reg && (!s2_reg.last || !out_valid_reg || result.ready);
    assign load2  = s1_valid_reg && (!s2_valid_reg || adv3);
    assign item.ready = !s1_valid_reg || load2;
    assign accept = item.valid && item.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= vovf_pkg::RST_FREE_RATIO_THRESHOLD;
            min_filled_reg <= vovf_pkg::RST_MIN_FILLED_POINTS;
            min_free_reg   <= vovf_pkg::RST_MIN_FREE_CAMERAS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vovf_pkg::REG_FREE_RATIO_THRESHOLD:
                    thr_reg <= cfg_data[vovf_pkg::THR_W-1:0];
                vovf_pkg::REG_MIN_FILLED_POINTS:
                    min_filled_reg <= cfg_data[vovf_pkg::COUNT_W-1:0];
                vovf_pkg::REG_MIN_FREE_CAMERAS:
                    min_free_reg <= cfg_data[vovf_pkg::TALLY_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (load2)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (load2)
            s2_valid_next = 1'b1;
        else if (adv3)
            s2_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv3 && s2_reg.last)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // threshold complement, 1.0 - thr; unused when thr exceeds 1.0
    assign thr_over = thr_reg[vovf_pkg::THR_W-1] && (thr_reg[vovf_pkg::THR_W-2:0] != '0);
    assign thr_comp = vovf_pkg::Q16_ONE - thr_reg;

    // product stage
    always_comb
    begin
        s2_next.free_prod = vovf_pkg::PROD_W'(s1_free_reg) * vovf_pkg::PROD_W'(thr_comp);
        s2_next.fill_prod = vovf_pkg::PROD_W'(s1_fill_reg) * vovf_pkg::PROD_W'(thr_reg);
        s2_next.free_nz   = (s1_free_reg != '0);
        s2_next.fill_nz   = (s1_fill_reg != '0);
        s2_next.thr_over  = thr_over;
        s2_next.prior     = s1_prior_reg;
        s2_next.last      = s1_last_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_free_reg  <= item.free_rays;
            // outlier filled counts read as zero
            s1_fill_reg  <= (item.filled_points >= min_filled_reg) ? item.filled_points : '0;
            s1_prior_reg <= item.prior_occupancy;
            s1_last_reg  <= item.last_camera;
        end
        if (load2)
            s2_reg <= s2_next;
        if (adv3 && s2_reg.last)
            out_reg <= tally_res;
    end

    vovf_tally u_tally (
        .clk              (clk),
        .rst_n            (rst_n),
        .min_free_cameras (min_free_reg),
        .stage            (s2_reg),
        .advance          (adv3),
        .res              (tally_res)
    );

    assign result.valid         = out_valid_reg;
    assign result.new_occupancy = out_reg.new_occupancy;
    assign result.free_votes    = out_reg.free_votes;
    assign result.filled_votes  = out_reg.filled_votes;

    `VOVF_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, item.ready,
        "intake blocked with empty input stage")
    `VOVF_ASSERT_NEXT(a_last_gives_result, adv3 && s2_reg.last, out_valid_reg,
        "last camera produced no result")
    `VOVF_ASSERT_NOW(a_filled_occupancy,
        out_valid_reg && (out_reg.filled_votes != '0),
        (out_reg.new_occupancy == vovf_pkg::OCC_FILLED) ||
        (out_reg.new_occupancy > vovf_pkg::OCC_UNKNOWN),
        "filled vote without filled occupancy")

endmodule
